[hdl/xmodem_crc_block_sender_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef XMODEM_CRC_BLOCK_SENDER_TOP_DEFINES_SVH
`define XMODEM_CRC_BLOCK_SENDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define XCBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xcbs: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define XCBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xcbs: next-cycle check failed");

`endif

[hdl/xcbs_pkg.sv]
package xcbs_pkg;

  // Parameter defaults and limits
  localparam int DEF_BLOCK_BYTES  = 1024;
  localparam int DEF_LENGTH_WIDTH = 24;
  localparam int MAX_LEN_W        = 32;
  localparam int SMALL_BLOCK      = 128;

  // Request codes
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_DATA  = 3'd1;
  localparam logic [2:0] REQ_RX    = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_SLOT  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_PROG = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Finish status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_START_TO  = 3'd2;
  localparam logic [2:0] ST_CSUM_MODE = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_BLK_FAIL  = 3'd5;
  localparam logic [2:0] ST_EOT_NOANS = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_LARGE     = 2'd0;
  localparam logic [1:0] CFG_REPLY_TO  = 2'd1;
  localparam logic [1:0] CFG_START_TO  = 2'd2;
  localparam logic [1:0] CFG_MAX_TRIES = 2'd3;

  // Configuration reset values
  localparam logic        RST_LARGE     = 1'b1;
  localparam logic [15:0] RST_REPLY_TO  = 16'd15000;
  localparam logic [15:0] RST_START_TO  = 16'd10000;
  localparam logic [3:0]  RST_MAX_TRIES = 4'd3;

  // Line characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_PAD = 8'h1A;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Where the byte of a transmit result comes from
  typedef enum logic [2:0] {
    SRC_FIXED  = 3'd0,  // constant byte, no CRC
    SRC_PAD    = 3'd1,  // constant payload byte, goes into CRC
    SRC_STORE  = 3'd2,  // payload byte from block store, goes into CRC
    SRC_CRC_HI = 3'd3,
    SRC_CRC_LO = 3'd4
  } src_t;

  // Token from the control stage to the output stage
  typedef struct packed {
    logic                 emit;
    logic                 crc_clr;
    src_t                 src;
    logic [1:0]           kind;
    logic [7:0]           tx;
    logic [MAX_LEN_W-1:0] prog;
    logic [2:0]           status;
  } tok_t;

  // One byte of CRC-16/XMODEM
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

[hdl/xcbs_store.sv]
module xcbs_store #(
  parameter int BLOCK_BYTES = xcbs_pkg::DEF_BLOCK_BYTES
) (
  input  logic                           clk,
  input  logic                           mem_we,
  input  logic [$clog2(BLOCK_BYTES)-1:0] mem_waddr,
  input  logic [7:0]                     mem_wdata,
  input  logic                           mem_re,
  input  logic [$clog2(BLOCK_BYTES)-1:0] mem_raddr,
  output logic [7:0]                     mem_rdata
);

  logic [7:0] mem [BLOCK_BYTES];
  logic [7:0] rdata_r;

  // Block payload buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

[hdl/xcbs_ctrl.sv]
module xcbs_ctrl #(
  parameter int BLOCK_BYTES  = xcbs_pkg::DEF_BLOCK_BYTES,
  parameter int LENGTH_WIDTH = xcbs_pkg::DEF_LENGTH_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_req_type,
  input  logic [LENGTH_WIDTH-1:0]        in_total_length,
  input  logic [7:0]                     in_data_byte,
  input  logic [7:0]                     in_rx_byte,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data,
  // block store
  output logic                           mem_we,
  output logic [$clog2(BLOCK_BYTES)-1:0] mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(BLOCK_BYTES)-1:0] mem_raddr,
  // token to output stage
  output xcbs_pkg::tok_t                 tok,
  output logic                           tok_valid,
  input  logic                           tok_adv
);

  import xcbs_pkg::*;

  localparam int AW  = $clog2(BLOCK_BYTES);
  localparam int FCW = $clog2(BLOCK_BYTES + 1);
  localparam int SPW = $clog2(BLOCK_BYTES + 5);
  localparam int CW  = ((LENGTH_WIDTH > FCW) ? LENGTH_WIDTH : FCW) + 1;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_WAIT_START = 7'b0000010,
    PH_FILL       = 7'b0000100,
    PH_SEND       = 7'b0001000,
    PH_WAIT_REPLY = 7'b0010000,
    PH_SEND_EOT   = 7'b0100000,
    PH_WAIT_EOT   = 7'b1000000
  } phase_t;

  // configuration registers
  logic        large_r;
  logic [15:0] reply_to_r;
  logic [15:0] start_to_r;
  logic [3:0]  max_tries_r;

  // transfer state
  phase_t                  phase_r, phase_nxt;
  logic [FCW-1:0]          fill_r, fill_nxt;
  logic [SPW-1:0]          spos_r, spos_nxt;
  logic [7:0]              bnum_r, bnum_nxt;
  logic [LENGTH_WIDTH-1:0] left_r, left_nxt;
  logic [LENGTH_WIDTH-1:0] done_r, done_nxt;
  logic [3:0]              tries_r, tries_nxt;
  logic [15:0]             timer_r, timer_nxt;
  tok_t                    tok_r, tok_nxt;
  logic                    tok_v_r, tok_v_nxt;

  logic                    in_acc;
  logic [FCW-1:0]          bsize;
  logic [FCW-1:0]          fill_inc;
  logic [SPW-1:0]          crc_pos;
  logic [SPW-1:0]          pay_idx;
  logic [3:0]              try_lim;
  logic                    give_up;
  logic [CW-1:0]           left_ext;
  logic [CW-1:0]           fill_ext;

  // Hold items while the token stage cannot drain
  assign in_stall  = tok_v_r && !tok_adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign bsize    = large_r ? FCW'(BLOCK_BYTES) : FCW'(SMALL_BLOCK);
  assign fill_inc = fill_r + FCW'(1);
  assign crc_pos  = SPW'(bsize) + SPW'(3);
  assign pay_idx  = spos_r - SPW'(3);
  assign try_lim  = (max_tries_r == 4'd0) ? 4'd1 : max_tries_r;
  assign give_up  = (tries_r >= try_lim);
  assign left_ext = CW'(left_r);
  assign fill_ext = CW'(fill_r);

  // Item decode and state update
  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    spos_nxt  = spos_r;
    bnum_nxt  = bnum_r;
    left_nxt  = left_r;
    done_nxt  = done_r;
    tries_nxt = tries_r;
    timer_nxt = timer_r;
    tok_nxt   = '0;
    mem_we    = 1'b0;
    mem_waddr = fill_r[AW-1:0];
    mem_wdata = in_data_byte;
    mem_re    = 1'b0;
    mem_raddr = pay_idx[AW-1:0];

    if (in_acc) begin
      case (in_req_type)
        REQ_START: begin
          done_nxt = '0;
          if (in_total_length == '0) begin
            phase_nxt      = PH_IDLE;
            tok_nxt.emit   = 1'b1;
            tok_nxt.kind   = KIND_DONE;
            tok_nxt.status = ST_BAD_LEN;
          end else begin
            left_nxt        = in_total_length;
            bnum_nxt        = 8'd1;
            fill_nxt        = '0;
            spos_nxt        = '0;
            tries_nxt       = '0;
            tok_nxt.crc_clr = 1'b1;
            timer_nxt       = start_to_r;
            phase_nxt       = PH_WAIT_START;
          end
        end

        REQ_DATA: begin
          if (phase_r == PH_FILL) begin
            if (fill_r < bsize) begin
              mem_we   = 1'b1;
              fill_nxt = fill_inc;
            end
            if (fill_nxt >= bsize || CW'(fill_nxt) >= left_ext) begin
              tries_nxt       = 4'd1;
              spos_nxt        = '0;
              tok_nxt.crc_clr = 1'b1;
              phase_nxt       = PH_SEND;
            end
          end
        end

        REQ_RX: begin
          if (phase_r == PH_WAIT_START) begin
            if (in_rx_byte == CH_C) begin
              phase_nxt = PH_FILL;
              fill_nxt  = '0;
            end else if (in_rx_byte == CH_NAK || in_rx_byte == CH_CAN) begin
              phase_nxt      = PH_IDLE;
              tok_nxt.emit   = 1'b1;
              tok_nxt.kind   = KIND_DONE;
              tok_nxt.prog   = MAX_LEN_W'(done_r);
              tok_nxt.status = (in_rx_byte == CH_NAK) ? ST_CSUM_MODE : ST_CANCELLED;
            end
          end else if (phase_r == PH_WAIT_REPLY) begin
            if (in_rx_byte == CH_ACK) begin
              done_nxt     = LENGTH_WIDTH'(CW'(done_r) + fill_ext);
              left_nxt     = (left_ext >= fill_ext) ? LENGTH_WIDTH'(left_ext - fill_ext) : '0;
              bnum_nxt     = bnum_r + 8'd1;
              fill_nxt     = '0;
              phase_nxt    = (left_nxt != '0) ? PH_FILL : PH_SEND_EOT;
              tok_nxt.emit = 1'b1;
              tok_nxt.kind = KIND_PROG;
              tok_nxt.prog = MAX_LEN_W'(done_nxt);
            end else if (in_rx_byte == CH_CAN || (in_rx_byte == CH_NAK && give_up)) begin
              phase_nxt      = PH_IDLE;
              tok_nxt.emit   = 1'b1;
              tok_nxt.kind   = KIND_DONE;
              tok_nxt.prog   = MAX_LEN_W'(done_r);
              tok_nxt.status = (in_rx_byte == CH_CAN) ? ST_CANCELLED : ST_BLK_FAIL;
            end else if (in_rx_byte == CH_NAK) begin
              tries_nxt       = tries_r + 4'd1;
              spos_nxt        = '0;
              tok_nxt.crc_clr = 1'b1;
              phase_nxt       = PH_SEND;
            end
          end else if (phase_r == PH_WAIT_EOT && in_rx_byte == CH_ACK) begin
            phase_nxt      = PH_IDLE;
            tok_nxt.emit   = 1'b1;
            tok_nxt.kind   = KIND_DONE;
            tok_nxt.prog   = MAX_LEN_W'(done_r);
            tok_nxt.status = ST_OK;
          end
        end

        REQ_TICK: begin
          if (phase_r == PH_WAIT_START || phase_r == PH_WAIT_REPLY ||
              phase_r == PH_WAIT_EOT) begin
            if (timer_r > 16'd1) begin
              timer_nxt = timer_r - 16'd1;
            end else begin
              timer_nxt = '0;
              if (phase_r == PH_WAIT_REPLY && !give_up) begin
                // reply timeout: send the block again
                tries_nxt       = tries_r + 4'd1;
                spos_nxt        = '0;
                tok_nxt.crc_clr = 1'b1;
                phase_nxt       = PH_SEND;
              end else begin
                phase_nxt    = PH_IDLE;
                tok_nxt.emit = 1'b1;
                tok_nxt.kind = KIND_DONE;
                tok_nxt.prog = MAX_LEN_W'(done_r);
                if (phase_r == PH_WAIT_START) begin
                  tok_nxt.status = ST_START_TO;
                end else if (phase_r == PH_WAIT_EOT) begin
                  tok_nxt.status = ST_EOT_NOANS;
                end else begin
                  tok_nxt.status = ST_BLK_FAIL;
                end
              end
            end
          end
        end

        REQ_SLOT: begin
          if (phase_r == PH_SEND) begin
            tok_nxt.emit = 1'b1;
            tok_nxt.kind = KIND_TX;
            spos_nxt     = spos_r + SPW'(1);
            if (spos_r == SPW'(0)) begin
              tok_nxt.tx = large_r ? CH_STX : CH_SOH;
            end else if (spos_r == SPW'(1)) begin
              tok_nxt.tx = bnum_r;
            end else if (spos_r == SPW'(2)) begin
              tok_nxt.tx = ~bnum_r;
            end else if (spos_r < crc_pos) begin
              // payload byte: stored, or pad past the fill
              if (pay_idx < SPW'(fill_r)) begin
                tok_nxt.src = SRC_STORE;
                mem_re      = 1'b1;
              end else begin
                tok_nxt.src = SRC_PAD;
                tok_nxt.tx  = CH_PAD;
              end
            end else if (spos_r == crc_pos) begin
              tok_nxt.src = SRC_CRC_HI;
            end else begin
              tok_nxt.src = SRC_CRC_LO;
              phase_nxt   = PH_WAIT_REPLY;
              timer_nxt   = reply_to_r;
            end
          end else if (phase_r == PH_SEND_EOT) begin
            phase_nxt    = PH_WAIT_EOT;
            timer_nxt    = reply_to_r;
            tok_nxt.emit = 1'b1;
            tok_nxt.kind = KIND_TX;
            tok_nxt.tx   = CH_EOT;
          end
        end

        default: begin
        end
      endcase
    end
  end

  // Token stage occupancy
  always_comb begin
    tok_v_nxt = tok_v_r;
    if (in_acc) begin
      tok_v_nxt = 1'b1;
    end else if (tok_adv) begin
      tok_v_nxt = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_r     <= RST_LARGE;
      reply_to_r  <= RST_REPLY_TO;
      start_to_r  <= RST_START_TO;
      max_tries_r <= RST_MAX_TRIES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LARGE:     large_r     <= cfg_data[0];
        CFG_REPLY_TO:  reply_to_r  <= cfg_data;
        CFG_START_TO:  start_to_r  <= cfg_data;
        CFG_MAX_TRIES: max_tries_r <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Transfer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fill_r  <= '0;
      spos_r  <= '0;
      bnum_r  <= 8'd1;
      left_r  <= '0;
      done_r  <= '0;
      tries_r <= '0;
      timer_r <= '0;
      tok_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      spos_r  <= spos_nxt;
      bnum_r  <= bnum_nxt;
      left_r  <= left_nxt;
      done_r  <= done_nxt;
      tries_r <= tries_nxt;
      timer_r <= timer_nxt;
      tok_v_r <= tok_v_nxt;
    end
  end

  // Token payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok       = tok_r;
  assign tok_valid = tok_v_r;

endmodule

[hdl/xcbs_emit.sv]
module xcbs_emit #(
  parameter int LENGTH_WIDTH = xcbs_pkg::DEF_LENGTH_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  xcbs_pkg::tok_t          tok,
  input  logic                    tok_valid,
  output logic                    tok_adv,
  input  logic [7:0]              mem_rdata,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_tx_byte,
  output logic [LENGTH_WIDTH-1:0] out_progress_bytes,
  output logic [2:0]              out_status
);

  import xcbs_pkg::*;

  logic [15:0]             crc_r, crc_nxt;
  logic                    out_v_r, out_v_nxt;
  logic [1:0]              kind_r;
  logic [7:0]              tx_r;
  logic [LENGTH_WIDTH-1:0] prog_r;
  logic [2:0]              status_r;
  logic [7:0]              pay_byte;
  logic [7:0]              line_byte;
  logic                    take;

  // Token moves on whenever the output register is free or draining
  assign tok_adv = !(out_v_r && out_stall);
  assign take    = tok_valid && tok_adv;

  assign pay_byte = (tok.src == SRC_STORE) ? mem_rdata : tok.tx;

  // Line byte selection
  always_comb begin
    case (tok.src)
      SRC_CRC_HI: line_byte = crc_r[15:8];
      SRC_CRC_LO: line_byte = crc_r[7:0];
      default:    line_byte = pay_byte;
    endcase
  end

  // CRC runs over payload bytes in send order
  always_comb begin
    crc_nxt = crc_r;
    if (take) begin
      if (tok.crc_clr) begin
        crc_nxt = '0;
      end else if (tok.src == SRC_STORE || tok.src == SRC_PAD) begin
        crc_nxt = crc16_byte(crc_r, pay_byte);
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take && tok.emit) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (take && tok.emit) begin
      kind_r   <= tok.kind;
      tx_r     <= (tok.kind == KIND_TX) ? line_byte : 8'h00;
      prog_r   <= tok.prog[LENGTH_WIDTH-1:0];
      status_r <= tok.status;
    end
  end

  assign out_valid          = out_v_r;
  assign out_kind           = kind_r;
  assign out_tx_byte        = tx_r;
  assign out_progress_bytes = prog_r;
  assign out_status         = status_r;

endmodule

[hdl/xmodem_crc_block_sender_top.sv]
// XMODEM-CRC block sender. Each accepted item (start, source byte, receiver
// byte, millisecond tick or transmit slot) yields at most one result: a line
// byte, an acknowledged-progress count or a finished status. One item is
// accepted per clock cycle while in_stall is low. Each item is registered in
// the token stage while a payload byte is read into the registered read port
// of the 1K block store, a synchronous RAM; then the token passes the CRC
// unit into the output register. The block stalls input only when both the
// token stage and the output register are full and the output side stalls.
// The block store needs no clearing after reset. Configuration may be written
// whenever no transaction is in flight and takes effect at once.
module xmodem_crc_block_sender_top #(
  parameter int BLOCK_BYTES  = xcbs_pkg::DEF_BLOCK_BYTES,
  parameter int LENGTH_WIDTH = xcbs_pkg::DEF_LENGTH_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_req_type,
  input  logic [LENGTH_WIDTH-1:0] in_total_length,
  input  logic [7:0]              in_data_byte,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_tx_byte,
  output logic [LENGTH_WIDTH-1:0] out_progress_bytes,
  output logic [2:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  import xcbs_pkg::*;

  localparam int AW = $clog2(BLOCK_BYTES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  tok_t          tok;
  logic          tok_valid;
  logic          tok_adv;

  xcbs_ctrl #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_total_length (in_total_length),
    .in_data_byte    (in_data_byte),
    .in_rx_byte      (in_rx_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .tok             (tok),
    .tok_valid       (tok_valid),
    .tok_adv         (tok_adv)
  );

  xcbs_store #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_store (
    .clk       (clk),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  xcbs_emit #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .tok                (tok),
    .tok_valid          (tok_valid),
    .tok_adv            (tok_adv),
    .mem_rdata          (mem_rdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_progress_bytes (out_progress_bytes),
    .out_status         (out_status)
  );

endmodule

[hdl/xcbs_checker.sv]
`include "xmodem_crc_block_sender_top_defines.svh"

module xcbs_checker #(
  parameter int LENGTH_WIDTH = xcbs_pkg::DEF_LENGTH_WIDTH
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              out_kind,
  input logic [7:0]              out_tx_byte,
  input logic [LENGTH_WIDTH-1:0] out_progress_bytes,
  input logic [2:0]              out_status
);

  import xcbs_pkg::*;

  // Line bytes carry no count and no status
  `XCBS_ASSERT_IMP(a_tx_clean, out_valid && out_kind == KIND_TX, out_progress_bytes == '0 && out_status == ST_OK)

  // Progress results carry no line byte and a zero status
  `XCBS_ASSERT_IMP(a_prog_clean, out_valid && out_kind == KIND_PROG, out_tx_byte == 8'h00 && out_status == ST_OK)

  // Input is only held back by a full, stalled output side
  `XCBS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

  // A stalled result stays put
  `XCBS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_tx_byte))

endmodule

bind xmodem_crc_block_sender_top xcbs_checker #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_xcbs_chk (.*);
